[rtl/core/dcce_pkg.sv]
// Shared types and constants of the drilling canned cycle expander.
`timescale 1ns / 1ps
package dcce_pkg;

   // G codes the expander reacts to
   localparam logic [6:0] G_CANCEL      = 7'd80;
   localparam logic [6:0] G_DRILL       = 7'd81;
   localparam logic [6:0] G_DRILL_DWELL = 7'd82;
   localparam logic [6:0] G_PECK        = 7'd83;
   localparam logic [6:0] G_RET_INITIAL = 7'd98;
   localparam logic [6:0] G_RET_R       = 7'd99;

   // word_mask bit positions
   localparam int WB_G = 0;
   localparam int WB_X = 1;
   localparam int WB_Y = 2;
   localparam int WB_Z = 3;
   localparam int WB_R = 4;
   localparam int WB_F = 5;
   localparam int WB_Q = 6;
   localparam int WB_P = 7;

   // move kinds on the result channel
   localparam logic [2:0] KIND_RAPID_XY = 3'd0;
   localparam logic [2:0] KIND_RAPID_Z  = 3'd1;
   localparam logic [2:0] KIND_FEED_Z   = 3'd2;
   localparam logic [2:0] KIND_DWELL_S  = 3'd3;
   localparam logic [2:0] KIND_DWELL_MS = 3'd4;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_RAPID_XY,
      ST_RAPID_R,
      ST_PECK_FEED,
      ST_PECK_RAPID,
      ST_FEED,
      ST_DWELL,
      ST_RETRACT,
      ST_CANCEL
   } state_type;

endpackage

[rtl/core/dcce_req_if.sv]
// Command channel: one parsed G-code command per item.
`timescale 1ns / 1ps
interface dcce_req_if;
   logic               valid;
   logic               ready;
   logic        [6:0]  mode;
   logic        [7:0]  word_mask;
   logic               abs_positioning;
   logic signed [31:0] machine_z;
   logic signed [31:0] word_x;
   logic signed [31:0] word_y;
   logic signed [31:0] word_z;
   logic signed [31:0] word_r;
   logic        [31:0] word_f;
   logic signed [31:0] word_q;
   logic        [15:0] word_p;

   modport source (
      output valid, mode, word_mask, abs_positioning, machine_z,
             word_x, word_y, word_z, word_r, word_f, word_q, word_p,
      input  ready
   );
   modport sink (
      input  valid, mode, word_mask, abs_positioning, machine_z,
             word_x, word_y, word_z, word_r, word_f, word_q, word_p,
      output ready
   );
endinterface

[rtl/core/dcce_rsp_if.sv]
// Move channel: one motion or dwell command per item.
`timescale 1ns / 1ps
interface dcce_rsp_if;
   logic               valid;
   logic               ready;
   logic        [2:0]  move_kind;
   logic        [1:0]  axis_present;
   logic signed [31:0] target_x;
   logic signed [31:0] target_y;
   logic signed [31:0] target_z;
   logic        [31:0] feed_rate;
   logic        [15:0] dwell_time;
   logic               last_move;

   modport source (
      output valid, move_kind, axis_present, target_x, target_y, target_z,
             feed_rate, dwell_time, last_move,
      input  ready
   );
   modport sink (
      input  valid, move_kind, axis_present, target_x, target_y, target_z,
             feed_rate, dwell_time, last_move,
      output ready
   );
endinterface

[rtl/core/drilling_canned_cycle_expander.sv]
// Top level of the drilling canned cycle expander (G80..G83, G98, G99).
`timescale 1ns / 1ps
// Expands canned drilling commands into single moves. G98/G99 open a cycle
// (G98 retracts to the Z sampled at that command, G99 to the R plane) and
// clear the held Z, R, F, Q and P words. G81/G82/G83 in absolute mode
// inside a cycle give rapid XY, rapid to R, optional pecks (feed down by
// Q, rapid back to R), the feed to Z (none when it pecks with Z at or
// above R), an optional dwell and the retract, the last one flagged by
// last_move. G80 closes the cycle and, under R retract, returns to the
// initial Z. A single step unit adds Q to the running peck depth,
// compares it with R - Z and steps the peck target down by Q, once per
// peck, for at most MAX_PECKS pecks. At most one move leaves per cycle
// through the output register, while the move channel is ready; the
// command channel is not ready until the last move of a hole has been
// loaded there.
module drilling_canned_cycle_expander
   import dcce_pkg::*;
#(
   parameter int MAX_PECKS = 29
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          csr_write_enable,
   input  logic          csr_write_data,
   dcce_req_if.sink      req_ch,
   dcce_rsp_if.source    rsp_ch
);

   // peck counter and running peck depth (up to (MAX_PECKS + 1) * Q)
   localparam int CntWidth = $clog2(MAX_PECKS + 1);
   localparam int AccWidth = 33 + CntWidth;

   // configuration
   logic dwell_in_millis_ff, dwell_in_millis_in;

   // cycle state
   state_type          state_ff, state_in;
   logic               cycle_active_ff, cycle_active_in;
   logic               retract_to_r_ff, retract_to_r_in;
   logic signed [31:0] initial_height_ff, initial_height_in;
   logic signed [31:0] retract_plane_ff, retract_plane_in;
   logic signed [31:0] held_depth_ff, held_depth_in;
   logic signed [31:0] held_r_ff, held_r_in;
   logic        [31:0] held_feed_ff, held_feed_in;
   logic signed [31:0] held_peck_ff, held_peck_in;
   logic        [15:0] held_dwell_ff, held_dwell_in;

   // per-hole working registers
   logic signed [31:0] hole_x_ff, hole_x_in;
   logic signed [31:0] hole_y_ff, hole_y_in;
   logic        [1:0]  hole_axes_ff, hole_axes_in;
   logic signed [33:0] depth_ff, depth_in;
   logic signed [AccWidth-1:0] acc_ff, acc_in;
   logic signed [31:0] peck_target_ff, peck_target_in;
   logic [CntWidth-1:0] peck_count_ff, peck_count_in;

   // output register
   logic               rsp_valid_ff, rsp_valid_in;
   logic        [2:0]  move_kind_ff, move_kind_in;
   logic        [1:0]  axis_present_ff, axis_present_in;
   logic signed [31:0] target_x_ff, target_x_in;
   logic signed [31:0] target_y_ff, target_y_in;
   logic signed [31:0] target_z_ff, target_z_in;
   logic        [31:0] feed_rate_ff, feed_rate_in;
   logic        [15:0] dwell_time_ff, dwell_time_in;
   logic               last_move_ff, last_move_in;

   // step unit: next peck depth, compare against R - Z, next peck target
   logic signed [AccWidth-1:0] step_acc;
   logic signed [31:0]         step_target;
   logic                       step_more;

   logic slot_free;
   logic req_fire;
   logic is_drill_code;

   assign step_acc    = acc_ff + AccWidth'(held_peck_ff);
   assign step_target = peck_target_ff - held_peck_ff;
   assign step_more   = (step_acc < AccWidth'(depth_ff)) &&
                        (peck_count_ff < CntWidth'(MAX_PECKS));

   assign slot_free = !rsp_valid_ff || rsp_ch.ready;
   assign req_ch.ready = (state_ff == ST_IDLE);
   assign req_fire = req_ch.valid && (state_ff == ST_IDLE);
   assign is_drill_code = (req_ch.mode == G_DRILL) || (req_ch.mode == G_DRILL_DWELL) ||
                          (req_ch.mode == G_PECK);

   always_comb begin
      // hold everything by default
      state_in          = state_ff;
      dwell_in_millis_in = csr_write_enable ? csr_write_data : dwell_in_millis_ff;
      cycle_active_in   = cycle_active_ff;
      retract_to_r_in   = retract_to_r_ff;
      initial_height_in = initial_height_ff;
      retract_plane_in  = retract_plane_ff;
      held_depth_in     = held_depth_ff;
      held_r_in         = held_r_ff;
      held_feed_in      = held_feed_ff;
      held_peck_in      = held_peck_ff;
      held_dwell_in     = held_dwell_ff;
      hole_x_in         = hole_x_ff;
      hole_y_in         = hole_y_ff;
      hole_axes_in      = hole_axes_ff;
      depth_in          = depth_ff;
      acc_in            = acc_ff;
      peck_target_in    = peck_target_ff;
      peck_count_in     = peck_count_ff;

      // drop the shown move once taken
      rsp_valid_in    = rsp_valid_ff && !rsp_ch.ready;
      move_kind_in    = move_kind_ff;
      axis_present_in = axis_present_ff;
      target_x_in     = target_x_ff;
      target_y_in     = target_y_ff;
      target_z_in     = target_z_ff;
      feed_rate_in    = feed_rate_ff;
      dwell_time_in   = dwell_time_ff;
      last_move_in    = last_move_ff;

      // a move loaded this cycle starts from all-zero fields
      if (slot_free && state_ff != ST_IDLE) begin
         axis_present_in = 2'd0;
         target_x_in     = 32'sd0;
         target_y_in     = 32'sd0;
         target_z_in     = 32'sd0;
         feed_rate_in    = 32'd0;
         dwell_time_in   = 16'd0;
         last_move_in    = 1'b0;
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_fire && req_ch.word_mask[WB_G]) begin
               if (req_ch.mode == G_RET_INITIAL || req_ch.mode == G_RET_R) begin
                  initial_height_in = req_ch.machine_z;
                  retract_to_r_in   = (req_ch.mode == G_RET_R);
                  held_depth_in     = 32'sd0;
                  held_r_in         = 32'sd0;
                  held_feed_in      = 32'd0;
                  held_peck_in      = 32'sd0;
                  held_dwell_in     = 16'd0;
                  cycle_active_in   = 1'b1;
               end else if (req_ch.mode == G_CANCEL) begin
                  cycle_active_in = 1'b0;
                  if (retract_to_r_ff) begin
                     state_in = ST_CANCEL;
                  end
               end else if (cycle_active_ff && req_ch.abs_positioning && is_drill_code) begin
                  if (req_ch.word_mask[WB_Z]) held_depth_in = req_ch.word_z;
                  if (req_ch.word_mask[WB_R]) held_r_in     = req_ch.word_r;
                  if (req_ch.word_mask[WB_F]) held_feed_in  = req_ch.word_f;
                  if (req_ch.word_mask[WB_Q]) held_peck_in  = req_ch.word_q;
                  if (req_ch.word_mask[WB_P]) held_dwell_in = req_ch.word_p;
                  hole_axes_in = {req_ch.word_mask[WB_Y], req_ch.word_mask[WB_X]};
                  hole_x_in = req_ch.word_mask[WB_X] ? req_ch.word_x : 32'sd0;
                  hole_y_in = req_ch.word_mask[WB_Y] ? req_ch.word_y : 32'sd0;
                  state_in  = ST_RAPID_XY;
               end
            end
         end
         ST_RAPID_XY: begin
            if (slot_free) begin
               rsp_valid_in    = 1'b1;
               move_kind_in    = KIND_RAPID_XY;
               axis_present_in = hole_axes_ff;
               target_x_in     = hole_x_ff;
               target_y_in     = hole_y_ff;
               retract_plane_in = retract_to_r_ff ? held_r_ff : initial_height_ff;
               depth_in = 34'(held_r_ff) - 34'(held_depth_ff);
               state_in = ST_RAPID_R;
            end
         end
         ST_RAPID_R: begin
            if (slot_free) begin
               rsp_valid_in   = 1'b1;
               move_kind_in   = KIND_RAPID_Z;
               target_z_in    = held_r_ff;
               acc_in         = '0;
               peck_target_in = held_r_ff;
               peck_count_in  = '0;
               if (held_peck_ff <= 32'sd0) begin
                  state_in = ST_FEED;
               end else if (depth_ff > 34'sd0) begin
                  state_in = ST_PECK_FEED;
               end else if (held_dwell_ff != 16'd0) begin
                  state_in = ST_DWELL;
               end else begin
                  state_in = ST_RETRACT;
               end
            end
         end
         ST_PECK_FEED: begin
            // advance one peck, or close the loop with the feed to Z
            if (!step_more) begin
               state_in = ST_FEED;
            end else if (slot_free) begin
               rsp_valid_in   = 1'b1;
               move_kind_in   = KIND_FEED_Z;
               target_z_in    = step_target;
               feed_rate_in   = held_feed_ff;
               acc_in         = step_acc;
               peck_target_in = step_target;
               peck_count_in  = peck_count_ff + CntWidth'(1);
               state_in       = ST_PECK_RAPID;
            end
         end
         ST_PECK_RAPID: begin
            if (slot_free) begin
               rsp_valid_in = 1'b1;
               move_kind_in = KIND_RAPID_Z;
               target_z_in  = held_r_ff;
               state_in     = ST_PECK_FEED;
            end
         end
         ST_FEED: begin
            if (slot_free) begin
               rsp_valid_in = 1'b1;
               move_kind_in = KIND_FEED_Z;
               target_z_in  = held_depth_ff;
               feed_rate_in = held_feed_ff;
               state_in     = (held_dwell_ff != 16'd0) ? ST_DWELL : ST_RETRACT;
            end
         end
         ST_DWELL: begin
            if (slot_free) begin
               rsp_valid_in  = 1'b1;
               move_kind_in  = dwell_in_millis_ff ? KIND_DWELL_MS : KIND_DWELL_S;
               dwell_time_in = held_dwell_ff;
               state_in      = ST_RETRACT;
            end
         end
         ST_RETRACT: begin
            if (slot_free) begin
               rsp_valid_in = 1'b1;
               move_kind_in = KIND_RAPID_Z;
               target_z_in  = retract_plane_ff;
               last_move_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         ST_CANCEL: begin
            if (slot_free) begin
               rsp_valid_in = 1'b1;
               move_kind_in = KIND_RAPID_Z;
               target_z_in  = initial_height_ff;
               last_move_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff           <= ST_IDLE;
         dwell_in_millis_ff <= 1'b0;
         cycle_active_ff    <= 1'b0;
         retract_to_r_ff    <= 1'b0;
         initial_height_ff  <= 32'sd0;
         retract_plane_ff   <= 32'sd0;
         held_depth_ff      <= 32'sd0;
         held_r_ff          <= 32'sd0;
         held_feed_ff       <= 32'd0;
         held_peck_ff       <= 32'sd0;
         held_dwell_ff      <= 16'd0;
         rsp_valid_ff       <= 1'b0;
      end else begin
         state_ff           <= state_in;
         dwell_in_millis_ff <= dwell_in_millis_in;
         cycle_active_ff    <= cycle_active_in;
         retract_to_r_ff    <= retract_to_r_in;
         initial_height_ff  <= initial_height_in;
         retract_plane_ff   <= retract_plane_in;
         held_depth_ff      <= held_depth_in;
         held_r_ff          <= held_r_in;
         held_feed_ff       <= held_feed_in;
         held_peck_ff       <= held_peck_in;
         held_dwell_ff      <= held_dwell_in;
         rsp_valid_ff       <= rsp_valid_in;
      end
   end

   // working and payload registers
   always_ff @(posedge clock) begin
      hole_x_ff       <= hole_x_in;
      hole_y_ff       <= hole_y_in;
      hole_axes_ff    <= hole_axes_in;
      depth_ff        <= depth_in;
      acc_ff          <= acc_in;
      peck_target_ff  <= peck_target_in;
      peck_count_ff   <= peck_count_in;
      move_kind_ff    <= move_kind_in;
      axis_present_ff <= axis_present_in;
      target_x_ff     <= target_x_in;
      target_y_ff     <= target_y_in;
      target_z_ff     <= target_z_in;
      feed_rate_ff    <= feed_rate_in;
      dwell_time_ff   <= dwell_time_in;
      last_move_ff    <= last_move_in;
   end

   assign rsp_ch.valid        = rsp_valid_ff;
   assign rsp_ch.move_kind    = move_kind_ff;
   assign rsp_ch.axis_present = axis_present_ff;
   assign rsp_ch.target_x     = target_x_ff;
   assign rsp_ch.target_y     = target_y_ff;
   assign rsp_ch.target_z     = target_z_ff;
   assign rsp_ch.feed_rate    = feed_rate_ff;
   assign rsp_ch.dwell_time   = dwell_time_ff;
   assign rsp_ch.last_move    = last_move_ff;

endmodule

[tb/tb_drilling_canned_cycle_expander.sv]
// Self-checking testbench of the drilling canned cycle expander.
`timescale 1ns / 1ps

import dcce_pkg::*;

// One parsed G-code command as it crosses the command channel
typedef struct packed {
   logic [6:0]  mode;
   logic [7:0]  word_mask;
   logic        abs_positioning;
   logic [31:0] machine_z;
   logic [31:0] word_x;
   logic [31:0] word_y;
   logic [31:0] word_z;
   logic [31:0] word_r;
   logic [31:0] word_f;
   logic [31:0] word_q;
   logic [15:0] word_p;
} gcode_cmd_type;

// One move as it leaves on the move channel
typedef struct packed {
   logic [2:0]  move_kind;
   logic [1:0]  axis_present;
   logic [31:0] target_x;
   logic [31:0] target_y;
   logic [31:0] target_z;
   logic [31:0] feed_rate;
   logic [15:0] dwell_time;
   logic        last_move;
} drill_move_type;

// Tracks the canned-cycle state and the moves each command expands to.
class drill_move_predictor #(int PECK_CAP = 29);
   bit          dwell_millis   = 1'b0;
   bit          cycle_on       = 1'b0;
   bit          retract_r      = 1'b0;
   logic [31:0] start_z        = '0;
   logic [31:0] retract_z      = '0;
   logic [31:0] hold_z         = '0;
   logic [31:0] hold_r         = '0;
   logic [31:0] hold_f         = '0;
   logic [31:0] hold_q         = '0;
   logic [15:0] hold_p         = '0;
   drill_move_type planned_moves[$];
   int unsigned commands_taken = 0;
   int unsigned holes_drilled  = 0;
   int unsigned moves_checked  = 0;
   int unsigned mismatches     = 0;
   int unsigned longest_pecks  = 0;

   function void push_move(logic [2:0] kind, logic [1:0] axes, logic [31:0] x,
                           logic [31:0] y, logic [31:0] z, logic [31:0] feed,
                           logic [15:0] dwell);
      drill_move_type m;
      m.move_kind    = kind;
      m.axis_present = axes;
      m.target_x     = x;
      m.target_y     = y;
      m.target_z     = z;
      m.feed_rate    = feed;
      m.dwell_time   = dwell;
      m.last_move    = 1'b0;
      planned_moves.push_back(m);
   endfunction

   function void take_command(gcode_cmd_type c);
      int          queued_before;
      longint      depth;
      longint      pecks;
      longint      peck_no;
      longint      peck_z;
      logic [31:0] tx;
      logic [31:0] ty;
      drill_move_type tail;
      queued_before = planned_moves.size();
      commands_taken++;
      if (!c.word_mask[WB_G])
         return;
      if (c.mode == G_RET_INITIAL || c.mode == G_RET_R) begin
         start_z   = c.machine_z;
         retract_r = (c.mode == G_RET_R);
         hold_z    = '0;
         hold_r    = '0;
         hold_f    = '0;
         hold_q    = '0;
         hold_p    = '0;
         cycle_on  = 1'b1;
      end else if (c.mode == G_CANCEL) begin
         // cancel returns to the start height under R retract, cycle or not
         cycle_on = 1'b0;
         if (retract_r)
            push_move(KIND_RAPID_Z, 2'b00, '0, '0, start_z, '0, '0);
      end else if (cycle_on && c.abs_positioning &&
                   (c.mode == G_DRILL || c.mode == G_DRILL_DWELL || c.mode == G_PECK)) begin
         holes_drilled++;
         if (c.word_mask[WB_Z]) hold_z = c.word_z;
         if (c.word_mask[WB_R]) hold_r = c.word_r;
         if (c.word_mask[WB_F]) hold_f = c.word_f;
         if (c.word_mask[WB_Q]) hold_q = c.word_q;
         if (c.word_mask[WB_P]) hold_p = c.word_p;
         retract_z = retract_r ? hold_r : start_z;
         tx = c.word_mask[WB_X] ? c.word_x : '0;
         ty = c.word_mask[WB_Y] ? c.word_y : '0;
         push_move(KIND_RAPID_XY, {c.word_mask[WB_Y], c.word_mask[WB_X]}, tx, ty, '0, '0, '0);
         push_move(KIND_RAPID_Z, 2'b00, '0, '0, hold_r, '0, '0);
         if ($signed(hold_q) > 0) begin
            // peck while the next step stays above Z, capped; then feed to Z
            depth = longint'($signed(hold_r)) - longint'($signed(hold_z));
            if (depth > 0) begin
               pecks = (depth - 1) / longint'($signed(hold_q));
               if (pecks > PECK_CAP)
                  pecks = PECK_CAP;
               if (pecks > longest_pecks)
                  longest_pecks = int'(pecks);
               for (peck_no = 1; peck_no <= pecks; peck_no++) begin
                  peck_z = longint'($signed(hold_r)) - peck_no * longint'($signed(hold_q));
                  push_move(KIND_FEED_Z, 2'b00, '0, '0, peck_z[31:0], hold_f, '0);
                  push_move(KIND_RAPID_Z, 2'b00, '0, '0, hold_r, '0, '0);
               end
               push_move(KIND_FEED_Z, 2'b00, '0, '0, hold_z, hold_f, '0);
            end
         end else begin
            push_move(KIND_FEED_Z, 2'b00, '0, '0, hold_z, hold_f, '0);
         end
         if (hold_p != 0)
            push_move(dwell_millis ? KIND_DWELL_MS : KIND_DWELL_S, 2'b00, '0, '0, '0, '0,
                      hold_p);
         push_move(KIND_RAPID_Z, 2'b00, '0, '0, retract_z, '0, '0);
      end
      if (planned_moves.size() > queued_before) begin
         tail = planned_moves[planned_moves.size() - 1];
         tail.last_move = 1'b1;
         planned_moves[planned_moves.size() - 1] = tail;
      end
   endfunction

   function void compare_field(string name, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
         mismatches++;
         if (mismatches <= 40)
            $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
      end
   endfunction

   function void check_move(drill_move_type got);
      drill_move_type want;
      moves_checked++;
      if (planned_moves.size() == 0) begin
         mismatches++;
         if (mismatches <= 40)
            $display("%0t: unexpected move, expected none, actual kind %0d target_z %h",
                     $time, got.move_kind, got.target_z);
         return;
      end
      want = planned_moves.pop_front();
      compare_field("move_kind", 32'(want.move_kind), 32'(got.move_kind));
      compare_field("axis_present", 32'(want.axis_present), 32'(got.axis_present));
      compare_field("target_x", want.target_x, got.target_x);
      compare_field("target_y", want.target_y, got.target_y);
      compare_field("target_z", want.target_z, got.target_z);
      compare_field("feed_rate", want.feed_rate, got.feed_rate);
      compare_field("dwell_time", 32'(want.dwell_time), 32'(got.dwell_time));
      compare_field("last_move", 32'(want.last_move), 32'(got.last_move));
   endfunction
endclass

module tb_drilling_canned_cycle_expander;

   localparam int PECK_LIMIT      = 29;
   localparam int ONE             = 65536;          // 1.0 in Q16.16
   localparam int SETTLE_CYCLES   = 2 * PECK_LIMIT + 10;
   localparam int PRESSURE_CYCLES = 400;
   localparam int PHASE_ITEMS     = 115;
   localparam int CYCLE_LIMIT     = 3000000;

   // word presence masks
   localparam logic [7:0] W_G   = 8'(1 << WB_G);
   localparam logic [7:0] W_X   = 8'(1 << WB_X);
   localparam logic [7:0] W_Y   = 8'(1 << WB_Y);
   localparam logic [7:0] W_Z   = 8'(1 << WB_Z);
   localparam logic [7:0] W_R   = 8'(1 << WB_R);
   localparam logic [7:0] W_F   = 8'(1 << WB_F);
   localparam logic [7:0] W_Q   = 8'(1 << WB_Q);
   localparam logic [7:0] W_P   = 8'(1 << WB_P);
   localparam logic [7:0] W_ALL = 8'hFF;

   logic clock;
   logic reset;
   logic csr_write_enable;
   logic csr_write_data;
   logic hold_rsp;
   int   sender_idle_pct;
   int   rsp_stall_pct;
   int   cycle_count;

   dcce_req_if req_ch ();
   dcce_rsp_if rsp_ch ();

   drill_move_predictor #(PECK_LIMIT) planner = new;

   drilling_canned_cycle_expander #(
      .MAX_PECKS (PECK_LIMIT)
   ) DUT (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .req_ch           (req_ch),
      .rsp_ch           (rsp_ch)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // Move side: random stalls per cycle, plus the long hold used to back the
   // block up into its command channel.
   always @(posedge clock) begin
      if (hold_rsp)
         rsp_ch.ready <= 1'b0;
      else
         rsp_ch.ready <= ($urandom_range(99) >= rsp_stall_pct);
   end

   // Check every move taken off the channel against the oldest planned one.
   always @(posedge clock) begin
      if (!reset && rsp_ch.valid && rsp_ch.ready)
         planner.check_move(drill_move_type'({rsp_ch.move_kind, rsp_ch.axis_present,
                                              rsp_ch.target_x, rsp_ch.target_y,
                                              rsp_ch.target_z, rsp_ch.feed_rate,
                                              rsp_ch.dwell_time, rsp_ch.last_move}));
   end

   // Watchdog: drop the run if it hangs.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("Timed out after %0d cycles with %0d moves outstanding",
                  cycle_count, planner.planned_moves.size());
         $display("FAIL");
         $finish;
      end
   end

   function automatic gcode_cmd_type make_command(logic [6:0] mode, logic [7:0] mask,
                                                  logic absolute, logic [31:0] mz,
                                                  logic [31:0] x, logic [31:0] y,
                                                  logic [31:0] z, logic [31:0] r,
                                                  logic [31:0] f, logic [31:0] q,
                                                  logic [15:0] p);
      gcode_cmd_type c;
      c.mode            = mode;
      c.word_mask       = mask;
      c.abs_positioning = absolute;
      c.machine_z       = mz;
      c.word_x          = x;
      c.word_y          = y;
      c.word_z          = z;
      c.word_r          = r;
      c.word_f          = f;
      c.word_q          = q;
      c.word_p          = p;
      return c;
   endfunction

   // Mostly moderate coordinates around zero, sometimes any 32-bit value or an extreme.
   function automatic logic [31:0] pick_coord(int unsigned span);
      case ($urandom_range(9))
         0: return $urandom;
         1: begin
            case ($urandom_range(3))
               0:       return 32'h8000_0000;
               1:       return 32'h7FFF_FFFF;
               2:       return 32'h0000_0000;
               default: return 32'hFFFF_FFFF;
            endcase
         end
         default: return $urandom_range(2 * span * ONE) - span * ONE;
      endcase
   endfunction

   // Peck step: mostly a few pecks per hole, now and then none, the cap, or noise.
   function automatic logic [31:0] pick_peck();
      case ($urandom_range(9))
         0:       return $urandom;
         1:       return -($urandom_range(3 * ONE));
         2:       return 32'd1;
         default: return $urandom_range(ONE / 2, 12 * ONE);
      endcase
   endfunction

   function automatic gcode_cmd_type random_command();
      gcode_cmd_type c;
      int unsigned   pick;
      pick = $urandom_range(99);
      if (pick < 12)
         c.mode = $urandom_range(1) ? G_RET_R : G_RET_INITIAL;
      else if (pick < 16)
         c.mode = G_CANCEL;
      else if (pick < 88) begin
         case ($urandom_range(2))
            0:       c.mode = G_DRILL;
            1:       c.mode = G_DRILL_DWELL;
            default: c.mode = G_PECK;
         endcase
      end else
         c.mode = 7'($urandom_range(127));
      c.word_mask         = 8'($urandom);
      c.word_mask[WB_G]   = ($urandom_range(19) != 0);
      c.abs_positioning   = ($urandom_range(9) != 0);
      c.machine_z         = pick_coord(40);
      c.word_x            = pick_coord(500);
      c.word_y            = pick_coord(500);
      c.word_z            = pick_coord(20);
      c.word_r            = pick_coord(10);
      c.word_f            = $urandom;
      c.word_q            = pick_peck();
      c.word_p            = ($urandom_range(3) == 0) ? 16'($urandom) : 16'($urandom_range(5));
      return c;
   endfunction

   // Offer one command, with random idle cycles ahead of it, and hold it
   // until the block takes it.
   task automatic send_command(input gcode_cmd_type c);
      while ($urandom_range(99) < sender_idle_pct) begin
         req_ch.valid <= 1'b0;
         @(posedge clock);
      end
      req_ch.valid           <= 1'b1;
      req_ch.mode            <= c.mode;
      req_ch.word_mask       <= c.word_mask;
      req_ch.abs_positioning <= c.abs_positioning;
      req_ch.machine_z       <= c.machine_z;
      req_ch.word_x          <= c.word_x;
      req_ch.word_y          <= c.word_y;
      req_ch.word_z          <= c.word_z;
      req_ch.word_r          <= c.word_r;
      req_ch.word_f          <= c.word_f;
      req_ch.word_q          <= c.word_q;
      req_ch.word_p          <= c.word_p;
      @(posedge clock);
      while (!req_ch.ready)
         @(posedge clock);
      planner.take_command(c);
   endtask

   // Wait for every planned move, then give a command that yields no moves
   // time to finish inside the block.
   task automatic wait_moves_drained();
      while (planner.planned_moves.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_dwell_unit(input bit millis);
      csr_write_enable <= 1'b1;
      csr_write_data   <= millis;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      planner.dwell_millis = millis;
   endtask

   task automatic run_phase(input int idle_pct, input int stall_pct, input bit millis,
                            input bit squeeze);
      wait_moves_drained();
      write_dwell_unit(millis);
      sender_idle_pct = idle_pct;
      rsp_stall_pct  <= stall_pct;
      fork
         if (squeeze) begin
            // hold the move side while commands keep coming, so the block backs up
            hold_rsp <= 1'b1;
            repeat (PRESSURE_CYCLES) @(posedge clock);
            hold_rsp <= 1'b0;
         end
         begin
            for (int k = 0; k < PHASE_ITEMS; k++)
               send_command(random_command());
            req_ch.valid <= 1'b0;
         end
      join
   endtask

   initial begin
      // known values on every input from time zero
      reset                  = 1'b1;
      csr_write_enable       = 1'b0;
      csr_write_data         = 1'b0;
      hold_rsp               = 1'b0;
      sender_idle_pct        = 0;
      rsp_stall_pct          = 0;
      cycle_count            = 0;
      rsp_ch.ready           = 1'b0;
      req_ch.valid           = 1'b0;
      req_ch.mode            = '0;
      req_ch.word_mask       = '0;
      req_ch.abs_positioning = 1'b0;
      req_ch.machine_z       = '0;
      req_ch.word_x          = '0;
      req_ch.word_y          = '0;
      req_ch.word_z          = '0;
      req_ch.word_r          = '0;
      req_ch.word_f          = '0;
      req_ch.word_q          = '0;
      req_ch.word_p          = '0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      write_dwell_unit(1'b1);

      // Directed part.
      // No G word: every other word present, nothing happens.
      send_command(make_command(G_DRILL, W_ALL & ~W_G, 1'b1, '0, ONE, ONE, -ONE, ONE,
                                ONE, '0, 16'd1));
      // Drill and cancel outside a cycle, retract to start height still in force.
      send_command(make_command(G_DRILL, W_ALL, 1'b1, '0, ONE, ONE, -ONE, ONE, ONE, '0,
                                16'd1));
      send_command(make_command(G_CANCEL, W_G, 1'b1, '0, '0, '0, '0, '0, '0, '0, '0));
      // R retract at the top of the Z range; cancel twice returns there both times.
      send_command(make_command(G_RET_R, W_G, 1'b1, 32'h7FFF_FFFF, '0, '0, '0, '0, '0,
                                '0, '0));
      send_command(make_command(G_CANCEL, W_G, 1'b1, '0, '0, '0, '0, '0, '0, '0, '0));
      send_command(make_command(G_CANCEL, W_G, 1'b1, '0, '0, '0, '0, '0, '0, '0, '0));
      send_command(make_command(G_RET_R, W_G, 1'b1, 32'h8000_0000, '0, '0, '0, '0, '0,
                                '0, '0));
      // Full word set at the field extremes, zero peck gives a plain feed plus dwell.
      send_command(make_command(G_DRILL, W_ALL, 1'b1, '0, 32'h8000_0000, 32'h7FFF_FFFF,
                                -5 * ONE, 2 * ONE, 32'hFFFF_FFFF, '0, 16'hFFFF));
      // Relative mode inside a cycle is skipped.
      send_command(make_command(G_DRILL_DWELL, W_ALL, 1'b0, '0, ONE, ONE, -ONE, ONE, ONE,
                                ONE, 16'd3));
      // G word only: held values reused, no XY given.
      send_command(make_command(G_DRILL_DWELL, W_G, 1'b1, '0, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                                '0, '0, '0, '0, '0));
      // Codes the block ignores.
      send_command(make_command(7'd0, W_ALL, 1'b1, '0, ONE, ONE, -ONE, ONE, ONE, ONE, 16'd1));
      send_command(make_command(7'h7F, W_ALL, 1'b1, '0, ONE, ONE, -ONE, ONE, ONE, ONE, 16'd1));
      // Retract to start height; depth an exact multiple of the peck step.
      send_command(make_command(G_RET_INITIAL, W_G, 1'b1, 10 * ONE, '0, '0, '0, '0, '0, '0,
                                '0));
      send_command(make_command(G_PECK, W_G | W_X | W_Z | W_R | W_F | W_Q, 1'b1, '0, 7 * ONE,
                                '0, -3 * ONE, 2 * ONE, 100 * ONE, ONE, '0));
      // Z above R with pecking on: no feed at all.
      send_command(make_command(G_PECK, W_G | W_Y | W_Z, 1'b1, '0, '0, -4 * ONE, 3 * ONE, '0,
                                '0, '0, '0));
      // Negative peck step falls back to a plain feed.
      send_command(make_command(G_PECK, W_G | W_Z | W_Q, 1'b1, '0, '0, '0, -ONE, '0, '0,
                                -ONE, '0));
      // Tiny peck step saturates the peck count, with a dwell: the longest hole.
      send_command(make_command(G_PECK, W_G | W_Z | W_Q | W_P, 1'b1, '0, '0, '0, -20 * ONE,
                                '0, '0, 32'd1, 16'd1));
      // Exactly the cap, then one past it.
      send_command(make_command(G_PECK, W_G | W_Z | W_Q, 1'b1, '0, '0, '0,
                                2 * ONE - 29 * ONE - 1, '0, '0, ONE, '0));
      send_command(make_command(G_PECK, W_G | W_Z, 1'b1, '0, '0, '0,
                                2 * ONE - 30 * ONE - 1, '0, '0, '0, '0));
      // Widest depth: the running peck depth goes past the 32-bit range.
      send_command(make_command(G_PECK, W_G | W_Z | W_R | W_Q, 1'b1, '0, '0, '0,
                                32'h8000_0000, 32'h7FFF_FFFF, '0, 32'h7FFF_FFFF, '0));
      // Zero dwell given explicitly: no dwell move.
      send_command(make_command(G_DRILL_DWELL, W_G | W_P | W_Q, 1'b1, '0, '0, '0, '0, '0,
                                '0, '0, '0));
      // Cancel under start-height retract gives nothing.
      send_command(make_command(G_CANCEL, W_G, 1'b1, '0, '0, '0, '0, '0, '0, '0, '0));
      // R retract, Z level with R, then cancel back to the start height.
      send_command(make_command(G_RET_R, W_G, 1'b1, -7 * ONE, '0, '0, '0, '0, '0, '0, '0));
      send_command(make_command(G_DRILL, W_G | W_X | W_Z | W_R, 1'b1, '0, -3 * ONE, '0, ONE,
                                ONE, '0, '0, '0));
      send_command(make_command(G_CANCEL, W_G, 1'b1, '0, '0, '0, '0, '0, '0, '0, '0));
      req_ch.valid <= 1'b0;

      // Random part, one handshake mix per phase, dwell unit flipped between them.
      run_phase(0, 0, 1'b0, 1'b1);
      run_phase(85, 0, 1'b1, 1'b0);
      run_phase(0, 85, 1'b0, 1'b0);
      run_phase(33, 33, 1'b1, 1'b0);

      wait_moves_drained();
      $display("Run covered %0d commands, %0d holes and %0d moves in both dwell units,",
               planner.commands_taken, planner.holes_drilled, planner.moves_checked);
      $display("four stall mixes, a %0d-cycle output hold and peck runs up to %0d.",
               PRESSURE_CYCLES, planner.longest_pecks);
      if (planner.mismatches == 0 && planner.planned_moves.size() == 0) begin
         $display("PASS");
      end else begin
         $display("%0d mismatches, %0d moves never seen", planner.mismatches,
                  planner.planned_moves.size());
         $display("FAIL");
      end
      $finish;
   end

endmodule

[files.f]
rtl/core/dcce_pkg.sv
rtl/core/dcce_req_if.sv
rtl/core/dcce_rsp_if.sv
rtl/core/drilling_canned_cycle_expander.sv
tb/tb_drilling_canned_cycle_expander.sv
